[src/nrmc_pkg.sv]
// ----------------------------------------------------------------------------
// nrmc_pkg: shared types and constants of the RMC sentence parser
// Character codes, field limits, fixed-point reciprocals and record types used
// by the front parser, the conversion back end, the top level and the checker.
// ----------------------------------------------------------------------------
package nrmc_pkg;

   // characters of the sentence grammar
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_M      = 8'h4D;
   localparam logic [7:0] CHAR_C      = 8'h43;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_A      = 8'h41;
   localparam logic [7:0] CHAR_V      = 8'h56;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;
   localparam logic [7:0] CHAR_DOT    = 8'h2E;
   localparam logic [7:0] CHAR_0      = 8'h30;
   localparam logic [7:0] CHAR_9      = 8'h39;
   localparam logic [7:0] CHAR_N      = 8'h4E;
   localparam logic [7:0] CHAR_S      = 8'h53;
   localparam logic [7:0] CHAR_E      = 8'h45;
   localparam logic [7:0] CHAR_W      = 8'h57;

   // byte positions of the sentence-type suffix check
   localparam int unsigned POS_HDR_M = 4;
   localparam int unsigned POS_HDR_C = 5;

   // comma field numbering
   localparam logic [2:0] FIELD_TIME   = 3'd1;
   localparam logic [2:0] FIELD_STATUS = 3'd2;
   localparam logic [2:0] FIELD_LAT    = 3'd3;
   localparam logic [2:0] FIELD_NS     = 3'd4;
   localparam logic [2:0] FIELD_LON    = 3'd5;
   localparam logic [2:0] FIELD_EW     = 3'd6;
   localparam logic [2:0] FIELD_MAX    = 3'd7;
   localparam logic [2:0] FIELDS_FULL  = 3'd6;

   // accumulator limits
   localparam logic [17:0] TIME_MAX      = 18'd262143;
   localparam logic [13:0] LAT_WHOLE_MAX = 14'd16383;
   localparam logic [14:0] LON_WHOLE_MAX = 15'd32767;

   // result limits
   localparam logic [26:0] LAT_OUT_MAX = 27'd90000000;
   localparam logic [27:0] LON_OUT_MAX = 28'd180000000;
   localparam logic [5:0]  MINUTE_MAX  = 6'd59;
   localparam logic [5:0]  HOURS_DAY   = 6'd24;
   localparam logic [5:0]  HOURS_2DAY  = 6'd48;

   // hour offset register
   localparam logic [4:0] OFFSET_RESET = 5'd7;

   // reciprocals: floor(x / d) == (x * R) >> S over the operand range used
   localparam logic [18:0] RECIP_10000 = 19'd429497;     // S = 32, x < 2^18
   localparam logic [13:0] RECIP_100_T = 14'd10486;      // S = 20, x < 10000
   localparam logic [15:0] RECIP_100_W = 16'd41944;      // S = 22, x < 2^15
   localparam logic [27:0] RECIP_60    = 28'd143165577;  // S = 33, x < 1e8

   localparam logic [17:0] TEN_THOUSAND = 18'd10000;
   localparam logic [14:0] ONE_HUNDRED  = 15'd100;
   localparam logic [28:0] ONE_MILLION  = 29'd1000000;

   // power of ten for elaboration-time constants
   function automatic int unsigned pow10(int unsigned n);
      int unsigned v;
      v = 1;
      for (int unsigned i = 0; i < n; i++) begin
         v = v * 10;
      end
      return v;
   endfunction

   // fixed-width part of one captured sentence
   typedef struct packed {
      logic [17:0] utc_time;
      logic        fix_active;
      logic        frame_error;
      logic [13:0] lat_whole;
      logic [14:0] lon_whole;
      logic        is_north;
      logic        is_east;
   } nrmc_fix_type;

   // one converted result
   typedef struct packed {
      logic [4:0]  local_hour;
      logic [5:0]  local_minute;
      logic        fix_status_active;
      logic        frame_error;
      logic [26:0] latitude_microdeg;
      logic        is_north;
      logic [27:0] longitude_microdeg;
      logic        is_east;
   } nrmc_result_type;

endpackage

[src/nrmc_fifo.sv]
// ----------------------------------------------------------------------------
// nrmc_fifo: short show-ahead queue
// Holds captured sentences between the parser and the conversion pipeline.
// DEPTH must be a power of two, at least two.
// ----------------------------------------------------------------------------
module nrmc_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int AW = $clog2(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW:0]      wr_ptr_ff, wr_ptr_in;
   logic [AW:0]      rd_ptr_ff, rd_ptr_in;

   // status flags from the pointer pair
   assign empty   = (wr_ptr_ff == rd_ptr_ff);
   assign full    = (wr_ptr_ff[AW] != rd_ptr_ff[AW]) &&
                    (wr_ptr_ff[AW-1:0] == rd_ptr_ff[AW-1:0]);
   assign rd_data = mem_ff[rd_ptr_ff[AW-1:0]];

   assign wr_ptr_in = (push && !full) ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = (pop && !empty) ? rd_ptr_ff + 1'b1 : rd_ptr_ff;

   // pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push && !full) begin
         mem_ff[wr_ptr_ff[AW-1:0]] <= wr_data;
      end
   end

endmodule

[src/nrmc_front.sv]
// ----------------------------------------------------------------------------
// nrmc_front: byte-level sentence parser
// Tracks the sentence, checks the header, accumulates time and coordinate
// digits per field and hands one classified record out on each good newline.
// ----------------------------------------------------------------------------
module nrmc_front #(
   parameter int FRAME_LIMIT     = 256,
   parameter int FRACTION_DIGITS = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [7:0]             rx_byte,
   output logic                   rec_push,
   output nrmc_pkg::nrmc_fix_type rec_fix,
   output logic [FRAC_W-1:0]      rec_lat_frac,
   output logic [FRAC_W-1:0]      rec_lon_frac
);

   localparam int FRAC_W = $clog2(nrmc_pkg::pow10(FRACTION_DIGITS));
   localparam int POS_W  = $clog2(FRAME_LIMIT + 1);
   localparam int CNT_W  = $clog2(FRACTION_DIGITS + 1);

   logic              in_sentence_ff, in_sentence_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [1:0]        header_ff, header_in;
   logic [2:0]        field_ff, field_in;
   logic [17:0]       time_ff, time_in;
   logic [13:0]       lat_whole_ff, lat_whole_in;
   logic [FRAC_W-1:0] lat_frac_ff, lat_frac_in;
   logic [14:0]       lon_whole_ff, lon_whole_in;
   logic [FRAC_W-1:0] lon_frac_ff, lon_frac_in;
   logic [CNT_W-1:0]  digits_ff, digits_in;
   logic              point_ff, point_in;
   logic [7:0]        status_ff, status_in;
   logic [1:0]        hemi_ff, hemi_in;

   logic              is_digit;
   logic [3:0]        digit;
   logic [1:0]        hdr;
   logic [21:0]       time_next;
   logic [17:0]       lat_whole_next;
   logic [18:0]       lon_whole_next;
   logic [FRAC_W-1:0] lat_pad, lon_pad;
   logic [FRAC_W-1:0] lat_frac_next, lon_frac_next;
   logic              frac_room;

   // byte classification
   always_comb begin
      is_digit = rx_byte inside {[nrmc_pkg::CHAR_0:nrmc_pkg::CHAR_9]};
      digit    = 4'(rx_byte - nrmc_pkg::CHAR_0);
   end

   // scale a short fraction up to the full digit count
   always_comb begin
      lat_pad = lat_frac_ff;
      lon_pad = lon_frac_ff;
      for (int k = 0; k <= FRACTION_DIGITS; k++) begin
         if (digits_ff == CNT_W'(k)) begin
            lat_pad = FRAC_W'(32'(lat_frac_ff) * nrmc_pkg::pow10(FRACTION_DIGITS - k));
            lon_pad = FRAC_W'(32'(lon_frac_ff) * nrmc_pkg::pow10(FRACTION_DIGITS - k));
         end
      end
   end

   // digit accumulation with saturation
   always_comb begin
      time_next      = 22'(time_ff) * 22'd10 + 22'(digit);
      lat_whole_next = 18'(lat_whole_ff) * 18'd10 + 18'(digit);
      lon_whole_next = 19'(lon_whole_ff) * 19'd10 + 19'(digit);
      frac_room      = (digits_ff < CNT_W'(FRACTION_DIGITS));
      lat_frac_next  = FRAC_W'(lat_frac_ff * FRAC_W'(10) + FRAC_W'(digit));
      lon_frac_next  = FRAC_W'(lon_frac_ff * FRAC_W'(10) + FRAC_W'(digit));
   end

   // next state of the parser
   always_comb begin
      in_sentence_in = in_sentence_ff;
      pos_in         = pos_ff;
      header_in      = header_ff;
      field_in       = field_ff;
      time_in        = time_ff;
      lat_whole_in   = lat_whole_ff;
      lat_frac_in    = lat_frac_ff;
      lon_whole_in   = lon_whole_ff;
      lon_frac_in    = lon_frac_ff;
      digits_in      = digits_ff;
      point_in       = point_ff;
      status_in      = status_ff;
      hemi_in        = hemi_ff;
      rec_push       = 1'b0;
      hdr            = header_ff;
      if (pos_ff == POS_W'(nrmc_pkg::POS_HDR_M)) begin
         hdr[0] = (rx_byte == nrmc_pkg::CHAR_M);
      end else if (pos_ff == POS_W'(nrmc_pkg::POS_HDR_C)) begin
         hdr[1] = (rx_byte == nrmc_pkg::CHAR_C);
      end

      if (accept && rx_byte == nrmc_pkg::CHAR_DOLLAR) begin
         // a dollar restarts everything
         in_sentence_in = 1'b1;
         pos_in         = POS_W'(1);
         header_in      = '0;
         field_in       = '0;
         time_in        = '0;
         lat_whole_in   = '0;
         lat_frac_in    = '0;
         lon_whole_in   = '0;
         lon_frac_in    = '0;
         digits_in      = '0;
         point_in       = 1'b0;
         status_in      = '0;
         hemi_in        = '0;
      end else if (accept && in_sentence_ff) begin
         header_in = hdr;
         if (pos_ff < POS_W'(FRAME_LIMIT)) begin
            pos_in = pos_ff + 1'b1;
         end
         if (rx_byte == nrmc_pkg::CHAR_LF) begin
            in_sentence_in = 1'b0;
            rec_push       = (hdr == 2'b11);
         end else if (rx_byte == nrmc_pkg::CHAR_COMMA) begin
            if (field_ff == nrmc_pkg::FIELD_LAT) begin
               lat_frac_in = lat_pad;
            end else if (field_ff == nrmc_pkg::FIELD_LON) begin
               lon_frac_in = lon_pad;
            end
            if (field_ff < nrmc_pkg::FIELD_MAX) begin
               field_in = field_ff + 1'b1;
            end
            digits_in = '0;
            point_in  = 1'b0;
         end else begin
            case (field_ff)
               nrmc_pkg::FIELD_TIME: begin
                  if (rx_byte == nrmc_pkg::CHAR_DOT) begin
                     point_in = 1'b1;
                  end else if (is_digit && !point_ff) begin
                     time_in = (time_next > 22'(nrmc_pkg::TIME_MAX)) ?
                               nrmc_pkg::TIME_MAX : time_next[17:0];
                  end
               end
               nrmc_pkg::FIELD_STATUS: begin
                  if (status_ff == 8'd0) begin
                     status_in = rx_byte;
                  end
               end
               nrmc_pkg::FIELD_LAT: begin
                  if (rx_byte == nrmc_pkg::CHAR_DOT) begin
                     point_in = 1'b1;
                  end else if (is_digit && !point_ff) begin
                     lat_whole_in = (lat_whole_next > 18'(nrmc_pkg::LAT_WHOLE_MAX)) ?
                                    nrmc_pkg::LAT_WHOLE_MAX : lat_whole_next[13:0];
                  end else if (is_digit && frac_room) begin
                     lat_frac_in = lat_frac_next;
                     digits_in   = digits_ff + 1'b1;
                  end
               end
               nrmc_pkg::FIELD_NS: begin
                  if (rx_byte == nrmc_pkg::CHAR_N) begin
                     hemi_in[0] = 1'b1;
                  end else if (rx_byte == nrmc_pkg::CHAR_S) begin
                     hemi_in[0] = 1'b0;
                  end
               end
               nrmc_pkg::FIELD_LON: begin
                  if (rx_byte == nrmc_pkg::CHAR_DOT) begin
                     point_in = 1'b1;
                  end else if (is_digit && !point_ff) begin
                     lon_whole_in = (lon_whole_next > 19'(nrmc_pkg::LON_WHOLE_MAX)) ?
                                    nrmc_pkg::LON_WHOLE_MAX : lon_whole_next[14:0];
                  end else if (is_digit && frac_room) begin
                     lon_frac_in = lon_frac_next;
                     digits_in   = digits_ff + 1'b1;
                  end
               end
               nrmc_pkg::FIELD_EW: begin
                  if (rx_byte == nrmc_pkg::CHAR_E) begin
                     hemi_in[1] = 1'b1;
                  end else if (rx_byte == nrmc_pkg::CHAR_W) begin
                     hemi_in[1] = 1'b0;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   // record handed to the queue, classified here
   always_comb begin
      rec_fix.utc_time    = time_ff;
      rec_fix.fix_active  = (status_ff == nrmc_pkg::CHAR_A);
      rec_fix.frame_error = (field_ff < nrmc_pkg::FIELDS_FULL) ||
                            (status_ff == nrmc_pkg::CHAR_V);
      rec_fix.lat_whole   = lat_whole_ff;
      rec_fix.lon_whole   = lon_whole_ff;
      rec_fix.is_north    = hemi_ff[0];
      rec_fix.is_east     = hemi_ff[1];
      rec_lat_frac = (field_ff == nrmc_pkg::FIELD_LAT) ? lat_pad : lat_frac_ff;
      rec_lon_frac = (field_ff == nrmc_pkg::FIELD_LON) ? lon_pad : lon_frac_ff;
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_sentence_ff <= 1'b0;
         pos_ff         <= '0;
         header_ff      <= '0;
         field_ff       <= '0;
         time_ff        <= '0;
         lat_whole_ff   <= '0;
         lat_frac_ff    <= '0;
         lon_whole_ff   <= '0;
         lon_frac_ff    <= '0;
         digits_ff      <= '0;
         point_ff       <= 1'b0;
         status_ff      <= '0;
         hemi_ff        <= '0;
      end else begin
         in_sentence_ff <= in_sentence_in;
         pos_ff         <= pos_in;
         header_ff      <= header_in;
         field_ff       <= field_in;
         time_ff        <= time_in;
         lat_whole_ff   <= lat_whole_in;
         lat_frac_ff    <= lat_frac_in;
         lon_whole_ff   <= lon_whole_in;
         lon_frac_ff    <= lon_frac_in;
         digits_ff      <= digits_in;
         point_ff       <= point_in;
         status_ff      <= status_in;
         hemi_ff        <= hemi_in;
      end
   end

endmodule

[src/nrmc_back.sv]
// ----------------------------------------------------------------------------
// nrmc_back: conversion pipeline
// Five stages turn a captured sentence into local time and microdegrees using
// constant reciprocals. The last stage is the result register; all stages
// advance together when it is free or being taken.
// ----------------------------------------------------------------------------
module nrmc_back #(
   parameter int FRACTION_DIGITS = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      rec_valid,
   input  nrmc_pkg::nrmc_fix_type    rec_fix,
   input  logic [FRAC_W-1:0]         rec_lat_frac,
   input  logic [FRAC_W-1:0]         rec_lon_frac,
   output logic                      rec_take,
   input  logic [4:0]                hour_offset,
   output logic                      out_valid,
   input  logic                      out_pop,
   output nrmc_pkg::nrmc_result_type out_result
);

   localparam int FRAC_W     = $clog2(nrmc_pkg::pow10(FRACTION_DIGITS));
   localparam int FRAC_SCALE = nrmc_pkg::pow10(6 - FRACTION_DIGITS);

   logic advance;

   // stage A: quotients by 10000 and 100
   logic                   a_valid_ff;
   nrmc_pkg::nrmc_fix_type a_fix_ff;
   logic [FRAC_W-1:0]      a_lat_frac_ff, a_lon_frac_ff;
   logic [4:0]             a_hour_ff, a_hour_in;
   logic [7:0]             a_lat_deg_ff, a_lat_deg_in;
   logic [8:0]             a_lon_deg_ff, a_lon_deg_in;
   logic [36:0]            a_hour_prod;
   logic [29:0]            a_lat_prod;
   logic [30:0]            a_lon_prod;

   // stage B: remainders and local hour
   logic                   b_valid_ff;
   nrmc_pkg::nrmc_fix_type b_fix_ff;
   logic [FRAC_W-1:0]      b_lat_frac_ff, b_lon_frac_ff;
   logic [7:0]             b_lat_deg_ff;
   logic [8:0]             b_lon_deg_ff;
   logic [4:0]             b_hour_ff, b_hour_in;
   logic [13:0]            b_rem_ff, b_rem_in;
   logic [6:0]             b_lat_mm_ff, b_lat_mm_in;
   logic [6:0]             b_lon_mm_ff, b_lon_mm_in;
   logic [17:0]            b_rem_full;
   logic [13:0]            b_lat_mm_full;
   logic [14:0]            b_lon_mm_full;
   logic [5:0]             b_hsum;

   // stage C: minute quotient, scaled minutes, whole degrees
   logic                   c_valid_ff;
   nrmc_pkg::nrmc_fix_type c_fix_ff;
   logic [4:0]             c_hour_ff;
   logic [6:0]             c_min_ff, c_min_in;
   logic [26:0]            c_lat_x_ff, c_lat_x_in;
   logic [26:0]            c_lon_x_ff, c_lon_x_in;
   logic [28:0]            c_lat_dm_ff, c_lat_dm_in;
   logic [28:0]            c_lon_dm_ff, c_lon_dm_in;
   logic [27:0]            c_min_prod;

   // stage D: minutes over sixty
   logic                   d_valid_ff;
   nrmc_pkg::nrmc_fix_type d_fix_ff;
   logic [4:0]             d_hour_ff;
   logic [5:0]             d_min_ff, d_min_in;
   logic [28:0]            d_lat_dm_ff, d_lon_dm_ff;
   logic [20:0]            d_lat_q_ff, d_lat_q_in;
   logic [20:0]            d_lon_q_ff, d_lon_q_in;
   logic [54:0]            d_lat_prod, d_lon_prod;

   // stage E: result register
   logic                      e_valid_ff;
   nrmc_pkg::nrmc_result_type e_result_ff, e_result_in;
   logic [29:0]               e_lat_sum, e_lon_sum;

   assign advance  = !e_valid_ff || out_pop;
   assign rec_take = advance && rec_valid;

   // stage A logic
   always_comb begin
      a_hour_prod  = 37'(rec_fix.utc_time) * 37'(nrmc_pkg::RECIP_10000);
      a_lat_prod   = 30'(rec_fix.lat_whole) * 30'(nrmc_pkg::RECIP_100_W);
      a_lon_prod   = 31'(rec_fix.lon_whole) * 31'(nrmc_pkg::RECIP_100_W);
      a_hour_in    = a_hour_prod[36:32];
      a_lat_deg_in = a_lat_prod[29:22];
      a_lon_deg_in = a_lon_prod[30:22];
   end

   // stage B logic
   always_comb begin
      b_rem_full    = a_fix_ff.utc_time - 18'(a_hour_ff) * nrmc_pkg::TEN_THOUSAND;
      b_lat_mm_full = a_fix_ff.lat_whole - 14'(a_lat_deg_ff) * 14'(nrmc_pkg::ONE_HUNDRED);
      b_lon_mm_full = a_fix_ff.lon_whole - 15'(a_lon_deg_ff) * nrmc_pkg::ONE_HUNDRED;
      b_rem_in      = b_rem_full[13:0];
      b_lat_mm_in   = b_lat_mm_full[6:0];
      b_lon_mm_in   = b_lon_mm_full[6:0];
      b_hsum        = 6'(a_hour_ff) + 6'(hour_offset);
      if (b_hsum >= nrmc_pkg::HOURS_2DAY) begin
         b_hour_in = 5'(b_hsum - nrmc_pkg::HOURS_2DAY);
      end else if (b_hsum >= nrmc_pkg::HOURS_DAY) begin
         b_hour_in = 5'(b_hsum - nrmc_pkg::HOURS_DAY);
      end else begin
         b_hour_in = b_hsum[4:0];
      end
   end

   // stage C logic
   always_comb begin
      c_min_prod  = 28'(b_rem_ff) * 28'(nrmc_pkg::RECIP_100_T);
      c_min_in    = c_min_prod[26:20];
      c_lat_x_in  = 27'(b_lat_mm_ff) * 27'(nrmc_pkg::ONE_MILLION) +
                    27'(b_lat_frac_ff) * 27'(FRAC_SCALE);
      c_lon_x_in  = 27'(b_lon_mm_ff) * 27'(nrmc_pkg::ONE_MILLION) +
                    27'(b_lon_frac_ff) * 27'(FRAC_SCALE);
      c_lat_dm_in = 29'(b_lat_deg_ff) * nrmc_pkg::ONE_MILLION;
      c_lon_dm_in = 29'(b_lon_deg_ff) * nrmc_pkg::ONE_MILLION;
   end

   // stage D logic
   always_comb begin
      d_lat_prod = 55'(c_lat_x_ff) * 55'(nrmc_pkg::RECIP_60);
      d_lon_prod = 55'(c_lon_x_ff) * 55'(nrmc_pkg::RECIP_60);
      d_lat_q_in = d_lat_prod[53:33];
      d_lon_q_in = d_lon_prod[53:33];
      d_min_in   = (c_min_ff > 7'(nrmc_pkg::MINUTE_MAX)) ?
                   nrmc_pkg::MINUTE_MAX : c_min_ff[5:0];
   end

   // stage E logic: add degrees and clamp
   always_comb begin
      e_lat_sum = 30'(d_lat_dm_ff) + 30'(d_lat_q_ff);
      e_lon_sum = 30'(d_lon_dm_ff) + 30'(d_lon_q_ff);
      e_result_in.local_hour        = d_hour_ff;
      e_result_in.local_minute      = d_min_ff;
      e_result_in.fix_status_active = d_fix_ff.fix_active;
      e_result_in.frame_error       = d_fix_ff.frame_error;
      e_result_in.is_north          = d_fix_ff.is_north;
      e_result_in.is_east           = d_fix_ff.is_east;
      e_result_in.latitude_microdeg = (e_lat_sum > 30'(nrmc_pkg::LAT_OUT_MAX)) ?
                                      nrmc_pkg::LAT_OUT_MAX : e_lat_sum[26:0];
      e_result_in.longitude_microdeg = (e_lon_sum > 30'(nrmc_pkg::LON_OUT_MAX)) ?
                                       nrmc_pkg::LON_OUT_MAX : e_lon_sum[27:0];
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= rec_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
         e_valid_ff <= d_valid_ff;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (advance) begin
         a_fix_ff      <= rec_fix;
         a_lat_frac_ff <= rec_lat_frac;
         a_lon_frac_ff <= rec_lon_frac;
         a_hour_ff     <= a_hour_in;
         a_lat_deg_ff  <= a_lat_deg_in;
         a_lon_deg_ff  <= a_lon_deg_in;

         b_fix_ff      <= a_fix_ff;
         b_lat_frac_ff <= a_lat_frac_ff;
         b_lon_frac_ff <= a_lon_frac_ff;
         b_lat_deg_ff  <= a_lat_deg_ff;
         b_lon_deg_ff  <= a_lon_deg_ff;
         b_hour_ff     <= b_hour_in;
         b_rem_ff      <= b_rem_in;
         b_lat_mm_ff   <= b_lat_mm_in;
         b_lon_mm_ff   <= b_lon_mm_in;

         c_fix_ff      <= b_fix_ff;
         c_hour_ff     <= b_hour_ff;
         c_min_ff      <= c_min_in;
         c_lat_x_ff    <= c_lat_x_in;
         c_lon_x_ff    <= c_lon_x_in;
         c_lat_dm_ff   <= c_lat_dm_in;
         c_lon_dm_ff   <= c_lon_dm_in;

         d_fix_ff      <= c_fix_ff;
         d_hour_ff     <= c_hour_ff;
         d_min_ff      <= d_min_in;
         d_lat_dm_ff   <= c_lat_dm_ff;
         d_lon_dm_ff   <= c_lon_dm_ff;
         d_lat_q_ff    <= d_lat_q_in;
         d_lon_q_ff    <= d_lon_q_in;

         e_result_ff   <= e_result_in;
      end
   end

   assign out_valid  = e_valid_ff;
   assign out_result = e_result_ff;

endmodule

[src/nmea_rmc_sentence_parser.sv]
// ----------------------------------------------------------------------------
// nmea_rmc_sentence_parser: RMC sentence to local time and position
// Throughput: one byte per cycle while req_full is low; the byte parser holds all per-field state.
// Path: a taken newline writes its record into the queue, then the record passes
// the five conversion stages; sentences queue up while rsp stalls.
// req_full rises only while the record queue is full.
// Reset: synchronous; clears the parser, queue and pipeline, offset back to 7.
// ----------------------------------------------------------------------------
module nmea_rmc_sentence_parser #(
   parameter int FRAME_LIMIT     = 256,
   parameter int FRACTION_DIGITS = 4,
   parameter int QUEUE_DEPTH     = 4
) (
   input  logic        clock,
   input  logic        reset,
   // byte input
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_rx_byte,
   // results
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [4:0]  rsp_local_hour,
   output logic [5:0]  rsp_local_minute,
   output logic        rsp_fix_status_active,
   output logic        rsp_frame_error,
   output logic [26:0] rsp_latitude_microdeg,
   output logic        rsp_is_north,
   output logic [27:0] rsp_longitude_microdeg,
   output logic        rsp_is_east,
   // configuration
   input  logic        csr_wr_en,
   input  logic [4:0]  csr_wr_data
);

   localparam int FRAC_W = $clog2(nrmc_pkg::pow10(FRACTION_DIGITS));
   localparam int FIX_W  = $bits(nrmc_pkg::nrmc_fix_type);
   localparam int REC_W  = FIX_W + 2 * FRAC_W;

   logic                      accept;
   logic                      rec_push;
   nrmc_pkg::nrmc_fix_type    rec_fix, q_fix;
   logic [FRAC_W-1:0]         rec_lat_frac, rec_lon_frac;
   logic [FRAC_W-1:0]         q_lat_frac, q_lon_frac;
   logic [REC_W-1:0]          q_wr_data, q_rd_data;
   logic                      q_full, q_empty, q_pop;
   logic [4:0]                hour_offset_ff;
   logic                      out_valid;
   nrmc_pkg::nrmc_result_type out_result;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   // hour offset register
   always_ff @(posedge clock) begin
      if (reset) begin
         hour_offset_ff <= nrmc_pkg::OFFSET_RESET;
      end else if (csr_wr_en) begin
         hour_offset_ff <= csr_wr_data;
      end
   end

   nrmc_front #(
      .FRAME_LIMIT     (FRAME_LIMIT),
      .FRACTION_DIGITS (FRACTION_DIGITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .rx_byte      (req_rx_byte),
      .rec_push     (rec_push),
      .rec_fix      (rec_fix),
      .rec_lat_frac (rec_lat_frac),
      .rec_lon_frac (rec_lon_frac)
   );

   // record queue between parser and conversion
   assign q_wr_data = {rec_fix, rec_lat_frac, rec_lon_frac};
   assign {q_fix, q_lat_frac, q_lon_frac} = q_rd_data;

   nrmc_fifo #(
      .WIDTH (REC_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (rec_push),
      .wr_data (q_wr_data),
      .full    (q_full),
      .pop     (q_pop),
      .rd_data (q_rd_data),
      .empty   (q_empty)
   );

   nrmc_back #(
      .FRACTION_DIGITS (FRACTION_DIGITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .rec_valid    (!q_empty),
      .rec_fix      (q_fix),
      .rec_lat_frac (q_lat_frac),
      .rec_lon_frac (q_lon_frac),
      .rec_take     (q_pop),
      .hour_offset  (hour_offset_ff),
      .out_valid    (out_valid),
      .out_pop      (rsp_pop),
      .out_result   (out_result)
   );

   // result ports
   assign rsp_empty              = !out_valid;
   assign rsp_local_hour         = out_result.local_hour;
   assign rsp_local_minute       = out_result.local_minute;
   assign rsp_fix_status_active  = out_result.fix_status_active;
   assign rsp_frame_error        = out_result.frame_error;
   assign rsp_latitude_microdeg  = out_result.latitude_microdeg;
   assign rsp_is_north           = out_result.is_north;
   assign rsp_longitude_microdeg = out_result.longitude_microdeg;
   assign rsp_is_east            = out_result.is_east;

endmodule

[src/nrmc_checker.sv]
// ----------------------------------------------------------------------------
// nrmc_checker: port-level checks of the RMC sentence parser
// Watches the result side for range slips and for stalled results that change; bound to the top.
// ----------------------------------------------------------------------------
module nrmc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [4:0]  rsp_local_hour,
   input logic [5:0]  rsp_local_minute,
   input logic        rsp_fix_status_active,
   input logic        rsp_frame_error,
   input logic [26:0] rsp_latitude_microdeg,
   input logic [27:0] rsp_longitude_microdeg
);

   // nothing waits on the result side just after reset
   a_empty_after_reset: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result shown right after reset");

   // time of day stays in range
   a_time_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_local_hour < 5'd24) && (rsp_local_minute <= nrmc_pkg::MINUTE_MAX))
      else $error("local time out of range");

   // position stays clamped
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_latitude_microdeg <= nrmc_pkg::LAT_OUT_MAX) &&
                     (rsp_longitude_microdeg <= nrmc_pkg::LON_OUT_MAX))
      else $error("position out of range");

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_local_hour) &&
         $stable(rsp_latitude_microdeg) && $stable(rsp_frame_error) &&
         $stable(rsp_fix_status_active))
      else $error("stalled result changed");

endmodule

bind nmea_rmc_sentence_parser nrmc_checker u_checker (.*);
